// ===== sv/bbe_pkg.sv =====
`timescale 1ns / 1ps

package bbe_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int HEIGHT_CAP = 4096;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CMP_W      = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } cfg_reg_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       frame_last;
    } pix_out_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             produce;
        logic             has_left;
        logic             has_right;
        logic             has_top;
        logic             has_bot;
        logic             last;
    } pos_t;

endpackage

// ===== sv/bbe_ram.sv =====
`timescale 1ns / 1ps

module bbe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bbe_pos.sv =====
`timescale 1ns / 1ps

module bbe_pos (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            accept,
    output bbe_pkg::pos_t                   pos
);

    import bbe_pkg::*;

    logic [WIDTH_W-1:0]  w_reg, w_next;
    logic [HEIGHT_W-1:0] h_reg, h_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    logic [COL_W-1:0]    c;
    logic                c_nz;
    logic                wrap;
    logic [WIDTH_W-1:0]  wdat;
    logic [HEIGHT_W-1:0] hdat;

    always_comb
    begin
        c    = (CMP_W'(col_reg) >= CMP_W'(w_reg)) ? '0 : col_reg;
        c_nz = (c != '0);
        wrap = (CMP_W'(c) + CMP_W'(1)) >= CMP_W'(w_reg);

        pos.col       = c;
        pos.produce   = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && c_nz);
        pos.has_left  = (CMP_W'(c) >= CMP_W'(2)) || (!c_nz && (w_reg > WIDTH_W'(1)));
        pos.has_right = c_nz;
        pos.has_top   = c_nz ? (row_reg >= ROW_W'(2)) : (row_reg >= ROW_W'(3));
        pos.has_bot   = c_nz ? (row_reg < ROW_W'(h_reg)) : (row_reg <= ROW_W'(h_reg));
        pos.last      = !c_nz
                        && ((ROW_W+1)'(row_reg) == ((ROW_W+1)'(h_reg) + (ROW_W+1)'(1)));
    end

    always_comb
    begin
        wdat   = cfg_data[WIDTH_W-1:0];
        hdat   = cfg_data[HEIGHT_W-1:0];
        w_next = w_reg;
        h_next = h_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:
                begin
                    if (wdat == '0)
                        w_next = WIDTH_W'(1);
                    else if (CMP_W'(wdat) > CMP_W'(MAX_WIDTH))
                        w_next = WIDTH_W'(MAX_WIDTH);
                    else
                        w_next = wdat;
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (hdat == '0)
                        h_next = HEIGHT_W'(1);
                    else if (hdat > HEIGHT_W'(HEIGHT_CAP))
                        h_next = HEIGHT_W'(HEIGHT_CAP);
                    else
                        h_next = hdat;
                end
                default:
                begin
                    w_next = w_reg;
                end
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (pos.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (wrap)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = c + COL_W'(1);
                row_next = row_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg   <= WIDTH_W'(640);
            h_reg   <= HEIGHT_W'(480);
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            w_reg   <= w_next;
            h_reg   <= h_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== sv/bbe_mean.sv =====
`timescale 1ns / 1ps

module bbe_mean (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  bbe_pkg::pos_t              pos,
    input  logic [bbe_pkg::PIX_W-1:0]  pix,
    input  logic [bbe_pkg::PIX_W-1:0]  above,
    input  logic [bbe_pkg::PIX_W-1:0]  two_above,
    output bbe_pkg::pix_out_t          res
);

    import bbe_pkg::*;

    localparam int DIV_SHIFT = 14;
    localparam int RCP_W     = DIV_SHIFT + 1;

    // reciprocal of the pixel count, scaled by 2^DIV_SHIFT
    function automatic logic [RCP_W-1:0] recip(input logic [3:0] count);
        logic [RCP_W-1:0] r;
        case (count)
            4'd2:    r = RCP_W'(8192);
            4'd3:    r = RCP_W'(5462);
            4'd4:    r = RCP_W'(4096);
            4'd6:    r = RCP_W'(2731);
            4'd9:    r = RCP_W'(1821);
            default: r = RCP_W'(16384);
        endcase
        return r;
    endfunction

    logic [PIX_W-1:0] win0_reg [3];
    logic [PIX_W-1:0] win1_reg [3];
    logic [PIX_W-1:0] fresh [3];

    logic [1:0]            ncols, nrows;
    logic [RCP_W-1:0]      rcp;
    logic [9:0]            cs_l, cs_m, cs_r;
    logic [11:0]           total [3];
    logic [RCP_W+11:0]     prod [3];

    always_comb
    begin
        fresh[0] = two_above;
        fresh[1] = above;
        fresh[2] = pix;
        ncols = 2'd1 + 2'(pos.has_left) + 2'(pos.has_right);
        nrows = 2'd1 + 2'(pos.has_top) + 2'(pos.has_bot);
        rcp   = recip(4'(ncols) * 4'(nrows));
        cs_l  = '0;
        cs_m  = '0;
        cs_r  = '0;
        for (int k = 0; k < 3; k++)
        begin
            cs_l = (pos.has_top ? 10'(win0_reg[0][8*k +: 8]) : 10'd0)
                   + 10'(win0_reg[1][8*k +: 8])
                   + (pos.has_bot ? 10'(win0_reg[2][8*k +: 8]) : 10'd0);
            cs_m = (pos.has_top ? 10'(win1_reg[0][8*k +: 8]) : 10'd0)
                   + 10'(win1_reg[1][8*k +: 8])
                   + (pos.has_bot ? 10'(win1_reg[2][8*k +: 8]) : 10'd0);
            cs_r = (pos.has_top ? 10'(fresh[0][8*k +: 8]) : 10'd0)
                   + 10'(fresh[1][8*k +: 8])
                   + (pos.has_bot ? 10'(fresh[2][8*k +: 8]) : 10'd0);
            total[k] = (pos.has_left ? 12'(cs_l) : 12'd0) + 12'(cs_m)
                       + (pos.has_right ? 12'(cs_r) : 12'd0);
            prod[k]  = (RCP_W+12)'(total[k]) * (RCP_W+12)'(rcp);
        end
        res.red_out    = prod[0][DIV_SHIFT +: 8];
        res.green_out  = prod[1][DIV_SHIFT +: 8];
        res.blue_out   = prod[2][DIV_SHIFT +: 8];
        res.alpha_out  = win1_reg[1][31:24];
        res.frame_last = pos.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 3; j++)
            begin
                win0_reg[j] <= '0;
                win1_reg[j] <= '0;
            end
        end
        else if (advance)
        begin
            for (int j = 0; j < 3; j++)
            begin
                win0_reg[j] <= win1_reg[j];
                win1_reg[j] <= fresh[j];
            end
        end
    end

endmodule

// ===== sv/box_blur_3x3_edge_normalized.sv =====
`timescale 1ns / 1ps

// channel  | signals                        | transfer when
// ---------+--------------------------------+----------------------------
// pixel in | pix_valid pix_ready pix_data   | pix_valid && pix_ready
// result   | res_valid res_ready res_data   | res_valid && res_ready
// config   | cfg_wr_en cfg_index cfg_data   | cfg_wr_en high at clk edge
//
// one item per clock sustained while res_ready holds; an item's line buffer ram
// read is registered beside the stage register, and its result in the result register
// the first image_width + 1 items of a frame give no result
// rst_n clears control, counters and the window; line buffers are not cleared
// a stalled result holds the stage behind it; input is taken while it drains

module box_blur_3x3_edge_normalized (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  bbe_pkg::pix_in_t                pix_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output bbe_pkg::pix_out_t               res_data,
    input  logic                            cfg_wr_en,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import bbe_pkg::*;

    logic             accept;
    logic             s1_go;
    pos_t             pos;

    logic             s1_valid_reg, s1_valid_next;
    pos_t             s1_pos_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             fwd_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;

    logic             res_valid_reg, res_valid_next;
    pix_out_t         res_data_reg;

    logic [2*PIX_W-1:0] ram_q;
    logic [2*PIX_W-1:0] wr_word;
    logic [PIX_W-1:0] above, two_above;
    logic [PIX_W-1:0] pix_in;
    pix_out_t         mean;

    assign s1_go     = s1_valid_reg && (!res_valid_reg || res_ready);
    assign pix_ready = !s1_valid_reg || s1_go;
    assign accept    = pix_valid && pix_ready;

    assign pix_in = pix_data.req_type ? '0 :
                    {pix_data.alpha_in, pix_data.blue_in, pix_data.green_in, pix_data.red_in};

    // same-column write in flight bypasses the read-first ram
    assign above     = fwd_reg ? fwd_data_reg[PIX_W-1:0] : ram_q[PIX_W-1:0];
    assign two_above = fwd_reg ? fwd_data_reg[2*PIX_W-1:PIX_W] : ram_q[2*PIX_W-1:PIX_W];
    assign wr_word   = {above, s1_pix_reg};

    bbe_pos u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pos       (pos)
    );

    bbe_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_pos_reg.col),
        .wdata (wr_word),
        .re    (accept),
        .raddr (pos.col),
        .rdata (ram_q)
    );

    bbe_mean u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_go),
        .pos       (s1_pos_reg),
        .pix       (s1_pix_reg),
        .above     (above),
        .two_above (two_above),
        .res       (mean)
    );

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        if (s1_go && s1_pos_reg.produce)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                fwd_reg <= s1_go && (s1_pos_reg.col == pos.col);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg   <= pos;
            s1_pix_reg   <= pix_in;
            fwd_data_reg <= wr_word;
        end
        if (s1_go && s1_pos_reg.produce)
        begin
            res_data_reg <= mean;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_full_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg |-> s1_go)
        else $error("item taken into an occupied stage that is not draining");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_pos_reg.produce |=> res_valid)
        else $error("producing item left no result");

    a_last_produces: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_pos_reg.last |-> s1_pos_reg.produce)
        else $error("frame end flagged on an item without a result");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> pix_ready)
        else $error("input stalled while the stage is empty");

endmodule
